>>> sv/grht_pkg.sv
package grht_pkg;

	localparam int GEN_W  = 32;
	localparam int RC_W   = 32;
	localparam int PAY_W  = 64;
	localparam int STAT_W = 3;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_RETAIN  = 2'd2;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NULL      = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_STALE     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 3'd4;
	localparam logic [STAT_W-1:0] STAT_SATURATED = 3'd5;

	localparam logic [RC_W-1:0]  REF_MAX  = 32'hFFFF_FFFF;
	localparam logic [GEN_W-1:0] GEN_INIT = 32'd1;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic             occupied;
		logic [GEN_W-1:0] generation;
		logic [RC_W-1:0]  refcount;
		logic [PAY_W-1:0] payload;
	} slot_t;

	typedef struct packed {
		logic rd_en;
		logic pop;
		logic push;
	} stk_ctl_t;

endpackage

>>> sv/grht_slot_mem.sv
module grht_slot_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output grht_pkg::slot_t      rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  grht_pkg::slot_t      wr_data
);

	grht_pkg::slot_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/grht_free_stack.sv
module grht_free_stack #(
	parameter int DEPTH   = 1024,
	parameter int ENTRY_W = 42,
	parameter int AW      = 10,
	parameter int CW      = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grht_pkg::stk_ctl_t   ctl,
	input  logic [ENTRY_W-1:0]   push_data,
	output logic [ENTRY_W-1:0]   rd_data,
	output logic [CW-1:0]        depth
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [CW-1:0]      depth_q;
	logic [CW-1:0]      top;

	assign top   = depth_q - CW'(1);
	assign depth = depth_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[depth_q[AW-1:0]] <= push_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[top[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ctl.pop) begin
			depth_q <= top;
		end else if (ctl.push) begin
			depth_q <= depth_q + CW'(1);
		end
	end

endmodule

>>> sv/generational_refcounted_handle_table.sv
// Generational handle table with reference counts. A command is taken when start is high
// and busy is low. Its result word appears on the result ports for exactly one cycle
// with done high, once the execute state has checked the command. The receiver cannot stall,
// so it must capture the word in that cycle. Each command first reads the slot memory
// (and, for allocate, the top of the free stack), then is checked, updated and written
// back in the execute state; busy covers that state, so a new command can be taken
// in the cycle in which done is shown. Slots past the high-water mark are never used
// and need no clearing after reset; the block accepts commands from the first cycle.
module generational_refcounted_handle_table #(
	parameter int  SLOT_COUNT = 1024,
	localparam int IW         = $clog2(SLOT_COUNT + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [grht_pkg::OP_W-1:0]     opcode,
	input  logic [IW-1:0]                 handle_index,
	input  logic [grht_pkg::GEN_W-1:0]    handle_generation,
	input  logic [grht_pkg::PAY_W-1:0]    payload,
	output logic                          done,
	output logic [grht_pkg::STAT_W-1:0]   status,
	output logic [IW-1:0]                 result_index,
	output logic [grht_pkg::GEN_W-1:0]    result_generation,
	output logic [grht_pkg::PAY_W-1:0]    result_payload,
	output logic [grht_pkg::RC_W-1:0]     result_refcount
);

	localparam int AW      = $clog2(SLOT_COUNT);
	localparam int ENTRY_W = AW + grht_pkg::GEN_W;

	grht_pkg::state_t   state_q, state_d;
	logic               accept;

	logic [grht_pkg::OP_W-1:0]  op_s1;
	logic [IW-1:0]              idx_s1;
	logic [grht_pkg::GEN_W-1:0] gen_s1;
	logic [grht_pkg::PAY_W-1:0] pay_s1;
	logic [AW-1:0]              pos_s1;

	logic [IW-1:0]  hwm_q, hwm_d;
	logic [IW-1:0]  idx_m1;

	grht_pkg::slot_t    slot_rd, slot_wr;
	logic               slot_wr_en;
	logic [AW-1:0]      slot_wr_addr;

	grht_pkg::stk_ctl_t stk_ctl;
	logic [ENTRY_W-1:0] stk_rd, stk_push;
	logic [IW-1:0]      stk_depth;

	logic                        done_q, done_d;
	logic [grht_pkg::STAT_W-1:0] status_q, status_d;
	logic [IW-1:0]               rindex_q, rindex_d;
	logic [grht_pkg::GEN_W-1:0]  rgen_q, rgen_d;
	logic [grht_pkg::PAY_W-1:0]  rpay_q, rpay_d;
	logic [grht_pkg::RC_W-1:0]   rrc_q, rrc_d;

	logic [AW-1:0]              alloc_pos;
	logic [grht_pkg::GEN_W-1:0] alloc_gen;
	logic                       alloc_ok;
	logic [grht_pkg::GEN_W-1:0] gen_next;

	assign busy   = (state_q == grht_pkg::S_EXEC);
	assign accept = start && !busy;
	assign idx_m1 = handle_index - IW'(1);
	assign gen_next = slot_rd.generation + grht_pkg::GEN_W'(1);

	grht_slot_mem #(
		.DEPTH (SLOT_COUNT),
		.AW    (AW)
	) u_slot_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (idx_m1[AW-1:0]),
		.rd_data (slot_rd),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr)
	);

	grht_free_stack #(
		.DEPTH   (SLOT_COUNT),
		.ENTRY_W (ENTRY_W),
		.AW      (AW),
		.CW      (IW)
	) u_free_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (stk_ctl),
		.push_data (stk_push),
		.rd_data   (stk_rd),
		.depth     (stk_depth)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			idx_s1 <= handle_index;
			gen_s1 <= handle_generation;
			pay_s1 <= payload;
			pos_s1 <= idx_m1[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grht_pkg::S_IDLE;
			hwm_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			hwm_q   <= hwm_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		rindex_q <= rindex_d;
		rgen_q   <= rgen_d;
		rpay_q   <= rpay_d;
		rrc_q    <= rrc_d;
	end

	// allocation source: free stack first, then a fresh slot
	always_comb begin
		alloc_ok  = 1'b1;
		alloc_pos = stk_rd[ENTRY_W-1:grht_pkg::GEN_W];
		alloc_gen = stk_rd[grht_pkg::GEN_W-1:0];
		priority if (stk_depth != '0) begin
			alloc_ok = 1'b1;
		end else if (hwm_q < IW'(SLOT_COUNT)) begin
			alloc_pos = hwm_q[AW-1:0];
			alloc_gen = grht_pkg::GEN_INIT;
		end else begin
			alloc_ok = 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		hwm_d        = hwm_q;
		slot_wr_en   = 1'b0;
		slot_wr_addr = pos_s1;
		slot_wr      = slot_rd;
		stk_ctl      = '0;
		stk_ctl.rd_en = accept && (opcode == grht_pkg::OP_ALLOC) && (stk_depth != '0);
		stk_push     = {pos_s1, gen_next};
		done_d       = 1'b0;
		status_d     = grht_pkg::STAT_OK;
		rindex_d     = '0;
		rgen_d       = '0;
		rpay_d       = '0;
		rrc_d        = '0;

		unique case (state_q)
			grht_pkg::S_IDLE: begin
				if (start) begin
					state_d = grht_pkg::S_EXEC;
				end
			end
			grht_pkg::S_EXEC: begin
				state_d = grht_pkg::S_IDLE;
				done_d  = 1'b1;
				if (op_s1 == grht_pkg::OP_ALLOC) begin
					if (!alloc_ok) begin
						status_d = grht_pkg::STAT_EXHAUSTED;
					end else begin
						stk_ctl.pop = (stk_depth != '0);
						if (stk_depth == '0) begin
							hwm_d = hwm_q + IW'(1);
						end
						slot_wr_en   = 1'b1;
						slot_wr_addr = alloc_pos;
						slot_wr      = '{occupied: 1'b1, generation: alloc_gen,
							refcount: grht_pkg::RC_W'(1), payload: pay_s1};
						rindex_d = IW'(alloc_pos) + IW'(1);
						rgen_d   = alloc_gen;
						rrc_d    = grht_pkg::RC_W'(1);
					end
				end else begin
					priority if (idx_s1 == '0 && gen_s1 == '0) begin
						status_d = grht_pkg::STAT_NULL;
					end else if (idx_s1 == '0 || idx_s1 > hwm_q) begin
						status_d = grht_pkg::STAT_RANGE;
					end else if (!slot_rd.occupied || slot_rd.generation != gen_s1) begin
						status_d = grht_pkg::STAT_STALE;
					end else begin
						rindex_d = idx_s1;
						rgen_d   = gen_s1;
						unique case (op_s1)
							grht_pkg::OP_READ: begin
								rpay_d = slot_rd.payload;
								rrc_d  = slot_rd.refcount;
							end
							grht_pkg::OP_RETAIN: begin
								if (slot_rd.refcount == grht_pkg::REF_MAX) begin
									status_d = grht_pkg::STAT_SATURATED;
									rrc_d    = grht_pkg::REF_MAX;
								end else begin
									slot_wr_en = 1'b1;
									slot_wr.refcount = slot_rd.refcount + grht_pkg::RC_W'(1);
									rrc_d = slot_wr.refcount;
								end
							end
							grht_pkg::OP_RELEASE: begin
								slot_wr_en = 1'b1;
								if (slot_rd.refcount > grht_pkg::RC_W'(1)) begin
									slot_wr.refcount = slot_rd.refcount - grht_pkg::RC_W'(1);
									rrc_d = slot_wr.refcount;
								end else begin
									// last reference: free, bump generation, push
									slot_wr.refcount   = '0;
									slot_wr.occupied   = 1'b0;
									slot_wr.generation = gen_next;
									stk_ctl.push = (stk_depth < IW'(SLOT_COUNT));
								end
							end
							default: begin
								status_d = grht_pkg::STAT_OK;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = grht_pkg::S_IDLE;
			end
		endcase
	end

	assign done              = done_q;
	assign status            = status_q;
	assign result_index      = rindex_q;
	assign result_generation = rgen_q;
	assign result_payload    = rpay_q;
	assign result_refcount   = rrc_q;

`ifndef SYNTH
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == grht_pkg::S_EXEC))
		else $error("result word without a preceding execute cycle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result word is shown");

	a_hwm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hwm_q <= IW'(SLOT_COUNT))
		else $error("high-water mark past slot count");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_depth <= hwm_q)
		else $error("more free slots than ever allocated");

	a_write_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_wr_en || stk_ctl.push || stk_ctl.pop) |-> state_q == grht_pkg::S_EXEC)
		else $error("state update outside the execute cycle");
`endif

endmodule

>>> tb/grht_checker.sv
module grht_checker #(
	parameter int SLOT_COUNT = 1024,
	parameter int IW         = $clog2(SLOT_COUNT + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [grht_pkg::OP_W-1:0]   opcode,
	input  logic [IW-1:0]               handle_index,
	input  logic [grht_pkg::GEN_W-1:0]  handle_generation,
	input  logic [grht_pkg::PAY_W-1:0]  payload,
	input  logic                        done,
	input  logic [grht_pkg::STAT_W-1:0] status,
	input  logic [IW-1:0]               result_index,
	input  logic [grht_pkg::GEN_W-1:0]  result_generation,
	input  logic [grht_pkg::PAY_W-1:0]  result_payload,
	input  logic [grht_pkg::RC_W-1:0]   result_refcount,
	output int                          errors,
	output int                          outstanding
);
	import grht_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IW-1:0]     index;
		logic [GEN_W-1:0]  generation;
		logic [PAY_W-1:0]  payload;
		logic [RC_W-1:0]   refcount;
	} table_word_t;

	logic [GEN_W-1:0] slot_gen  [SLOT_COUNT];
	logic [RC_W-1:0]  slot_refs [SLOT_COUNT];
	logic [PAY_W-1:0] slot_data [SLOT_COUNT];
	logic             slot_live [SLOT_COUNT];
	int unsigned      free_slots [SLOT_COUNT];
	int unsigned      free_count;
	int unsigned      high_water;
	table_word_t      pending_words [$];
	table_word_t      head_word;

	function automatic logic [STAT_W-1:0] validate_handle(input logic [IW-1:0] idx,
			input logic [GEN_W-1:0] gen);
		if (idx == 0 && gen == 0)
			return STAT_NULL;
		if (idx == 0 || idx > high_water || idx > SLOT_COUNT)
			return STAT_RANGE;
		if (!slot_live[idx-1] || slot_gen[idx-1] != gen)
			return STAT_STALE;
		return STAT_OK;
	endfunction

	function automatic table_word_t apply_command(input logic [OP_W-1:0] op,
			input logic [IW-1:0] idx, input logic [GEN_W-1:0] gen,
			input logic [PAY_W-1:0] pay);
		table_word_t w;
		int unsigned pos;
		w = '0;
		if (op == OP_ALLOC) begin
			// freed slots first, newest on top
			if (free_count > 0) begin
				free_count--;
				pos = free_slots[free_count];
			end else if (high_water < SLOT_COUNT) begin
				pos = high_water;
				high_water++;
			end else begin
				w.status = STAT_EXHAUSTED;
				return w;
			end
			slot_live[pos] = 1'b1;
			slot_refs[pos] = 1;
			slot_data[pos] = pay;
			w.status = STAT_OK;
			w.index = IW'(pos + 1);
			w.generation = slot_gen[pos];
			w.refcount = 1;
			return w;
		end
		w.status = validate_handle(idx, gen);
		if (w.status != STAT_OK)
			return w;
		pos = idx - 1;
		w.index = idx;
		w.generation = gen;
		case (op)
		OP_READ: begin
			w.payload = slot_data[pos];
			w.refcount = slot_refs[pos];
		end
		OP_RETAIN: begin
			if (slot_refs[pos] == REF_MAX) begin
				w.status = STAT_SATURATED;
				w.refcount = REF_MAX;
			end else begin
				slot_refs[pos]++;
				w.refcount = slot_refs[pos];
			end
		end
		default: begin
			if (slot_refs[pos] > 1) begin
				slot_refs[pos]--;
				w.refcount = slot_refs[pos];
			end else begin
				// last reference gone: free the slot and bump its generation
				slot_refs[pos] = 0;
				slot_live[pos] = 1'b0;
				slot_data[pos] = '0;
				slot_gen[pos] = slot_gen[pos] + 1;
				if (free_count < SLOT_COUNT) begin
					free_slots[free_count] = pos;
					free_count++;
				end
				w.refcount = 0;
			end
		end
		endcase
		return w;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_gen[i] = GEN_INIT;
				slot_refs[i] = '0;
				slot_data[i] = '0;
				slot_live[i] = 1'b0;
				free_slots[i] = 0;
			end
			free_count = 0;
			high_water = 0;
			pending_words.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got status %0d index %0d",
						$time, status, result_index);
					errors++;
				end else begin
					head_word = pending_words.pop_front();
					compare_field("status", head_word.status, status);
					compare_field("result_index", head_word.index, result_index);
					compare_field("result_generation", head_word.generation, result_generation);
					compare_field("result_payload", head_word.payload, result_payload);
					compare_field("result_refcount", head_word.refcount, result_refcount);
				end
			end
			if (start && !busy)
				pending_words = {pending_words, apply_command(opcode, handle_index,
					handle_generation, payload)};
			outstanding = pending_words.size();
		end
	end

endmodule

>>> tb/tb_generational_refcounted_handle_table.sv
module tb_generational_refcounted_handle_table;
	import grht_pkg::*;

	localparam int SLOT_COUNT  = 1024;
	localparam int IW          = $clog2(SLOT_COUNT + 1);
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [IW-1:0]    idx;
		logic [GEN_W-1:0] gen;
	} handle_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [OP_W-1:0]   opcode;
	logic [IW-1:0]     handle_index;
	logic [GEN_W-1:0]  handle_generation;
	logic [PAY_W-1:0]  payload;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [IW-1:0]     result_index;
	logic [GEN_W-1:0]  result_generation;
	logic [PAY_W-1:0]  result_payload;
	logic [RC_W-1:0]   result_refcount;
	int                errors;
	int                outstanding;

	handle_t           live_handles [$];
	handle_t           dead_handles [$];
	logic [OP_W-1:0]   issued_ops [$];
	int                status_seen [6] = '{default: 0};
	int                freed_count = 0;
	int                commands_sent = 0;
	int                calm_left = 0;

	generational_refcounted_handle_table #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.handle_index(handle_index),
		.handle_generation(handle_generation),
		.payload(payload),
		.done(done),
		.status(status),
		.result_index(result_index),
		.result_generation(result_generation),
		.result_payload(result_payload),
		.result_refcount(result_refcount)
	);

	grht_checker #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.handle_index(handle_index),
		.handle_generation(handle_generation),
		.payload(payload),
		.done(done),
		.status(status),
		.result_index(result_index),
		.result_generation(result_generation),
		.result_payload(result_payload),
		.result_refcount(result_refcount),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("generational_refcounted_handle_table test failed");
		$finish;
	end

	// track live handles from returned words so stimulus can build valid sequences
	always @(posedge clk) begin
		logic [OP_W-1:0] op_seen;
		handle_t h;
		if (arst_n) begin
			if (done && issued_ops.size() != 0) begin
				op_seen = issued_ops.pop_front();
				h.idx = result_index;
				h.gen = result_generation;
				if (status <= STAT_SATURATED)
					status_seen[status]++;
				if (status == STAT_OK && op_seen == OP_ALLOC) begin
					live_handles = {live_handles, h};
				end else if (status == STAT_OK && op_seen == OP_RELEASE && result_refcount == 0) begin
					freed_count++;
					for (int i = 0; i < live_handles.size(); i++) begin
						if (live_handles[i] == h) begin
							live_handles.delete(i);
							break;
						end
					end
					dead_handles = {dead_handles, h};
					if (dead_handles.size() > 16)
						void'(dead_handles.pop_front());
				end
			end
			if (start && !busy)
				issued_ops = {issued_ops, opcode};
		end
	end

	function automatic logic [PAY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input logic [OP_W-1:0] op, input logic [IW-1:0] idx,
			input logic [GEN_W-1:0] gen, input logic [PAY_W-1:0] pay);
		int gap;
		int r;
		start <= 1'b1;
		opcode <= op;
		handle_index <= idx;
		handle_generation <= gen;
		payload <= pay;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		commands_sent++;
		r = $urandom_range(99);
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else if (r < 3) begin
			calm_left = $urandom_range(10, 60);
			gap = 0;
		end else if (r < 50) begin
			gap = 0;
		end else if (r < 80) begin
			gap = $urandom_range(1, 3);
		end else if (r < 96) begin
			gap = $urandom_range(4, 9);
		end else begin
			gap = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic random_word(input int alloc_pct, input int release_pct, input int cap);
		int r;
		handle_t h;
		logic [OP_W-1:0] op;
		r = $urandom_range(99);
		h.idx = IW'($urandom_range(2047));
		h.gen = $urandom;
		if (r < 6) begin
			op = OP_W'($urandom_range(3));
			case ($urandom_range(4))
			0: h = '0;
			1: begin
				h.idx = '0;
				h.gen = h.gen | 32'd1;
			end
			2: begin
				if (dead_handles.size() != 0)
					h = dead_handles[$urandom_range(dead_handles.size() - 1)];
			end
			3: begin
				if (live_handles.size() != 0) begin
					h = live_handles[$urandom_range(live_handles.size() - 1)];
					h.gen = h.gen ^ (32'd1 << $urandom_range(31));
				end
			end
			default: ;
			endcase
		end else if (live_handles.size() == 0 ||
				(r < 6 + alloc_pct && live_handles.size() < cap)) begin
			op = OP_ALLOC;
		end else begin
			h = live_handles[$urandom_range(live_handles.size() - 1)];
			if (r >= 100 - release_pct)
				op = OP_RELEASE;
			else if (r[0])
				op = OP_READ;
			else
				op = OP_RETAIN;
		end
		send(op, h.idx, h.gen, rand64());
	endtask

	initial begin
		handle_t h;
		int base;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_ALLOC;
		handle_index = '0;
		handle_generation = '0;
		payload = '0;
		h = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: null, index zero, out of range
		send(OP_READ, '0, '0, rand64());
		send(OP_RETAIN, '0, 32'hFFFF_FFFF, rand64());
		send(OP_RELEASE, 11'd2047, 32'hFFFF_FFFF, rand64());
		send(OP_READ, 11'd1, GEN_INIT, rand64());
		send(OP_ALLOC, '0, '0, '1);
		send(OP_ALLOC, 11'd2047, '1, '0);
		send(OP_ALLOC, '0, '0, 64'hA5A5_5A5A_0F0F_F0F0);
		send(OP_READ, 11'd1, GEN_INIT, rand64());
		send(OP_READ, 11'd2, GEN_INIT, rand64());
		send(OP_RETAIN, 11'd1, GEN_INIT, rand64());
		send(OP_READ, 11'd1, GEN_INIT, rand64());
		send(OP_RELEASE, 11'd1, GEN_INIT, rand64());
		send(OP_RELEASE, 11'd1, GEN_INIT, rand64());
		// freed slot: old generation, then matching generation on an empty slot
		send(OP_READ, 11'd1, GEN_INIT, rand64());
		send(OP_READ, 11'd1, GEN_INIT + 1, rand64());
		send(OP_RELEASE, 11'd2, GEN_INIT, rand64());
		send(OP_ALLOC, '0, '0, rand64());
		send(OP_ALLOC, '0, '0, rand64());
		send(OP_ALLOC, '0, '0, rand64());
		send(OP_READ, 11'd2, GEN_INIT, rand64());
		send(OP_READ, 11'd4, GEN_INIT, rand64());
		send(OP_READ, 11'd5, GEN_INIT, rand64());
		send(OP_RETAIN, 11'd2, GEN_INIT + 1, rand64());
		send(OP_ALLOC, 11'd3, 32'd7, rand64());

		repeat (350) random_word(30, 25, 40);
		drain();

		// fill every slot until the table reports full
		base = status_seen[STAT_EXHAUSTED];
		for (int n = 0; n < 1100 && status_seen[STAT_EXHAUSTED] == base; n++)
			send(OP_ALLOC, IW'($urandom_range(2047)), $urandom, rand64());
		repeat (3) send(OP_ALLOC, IW'($urandom_range(2047)), $urandom, rand64());
		drain();

		foreach (live_handles[i])
			if (live_handles[i].idx == SLOT_COUNT)
				h = live_handles[i];
		send(OP_READ, h.idx, h.gen, rand64());
		send(OP_RETAIN, h.idx, h.gen, rand64());
		send(OP_RELEASE, h.idx, h.gen, rand64());
		send(OP_READ, IW'(SLOT_COUNT + 1), h.gen, rand64());

		repeat (200) random_word(10, 55, 4096);
		repeat (150) random_word(35, 25, 4096);

		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d words sent: %0d ok, %0d null, %0d out of range, %0d stale, %0d table full",
			commands_sent, status_seen[STAT_OK], status_seen[STAT_NULL],
			status_seen[STAT_RANGE], status_seen[STAT_STALE], status_seen[STAT_EXHAUSTED]);
		$display("%0d slots freed and recycled, table filled to all %0d slots, %0d mismatches",
			freed_count, SLOT_COUNT, errors);
		if (errors == 0 && outstanding == 0) begin
			$display("generational_refcounted_handle_table test passed");
		end else begin
			$display("generational_refcounted_handle_table test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/grht_pkg.sv
sv/grht_slot_mem.sv
sv/grht_free_stack.sv
sv/generational_refcounted_handle_table.sv
tb/grht_checker.sv
tb/tb_generational_refcounted_handle_table.sv
